// File: hw/rtl/tfd_pkg.sv
// Shared types and constants for the target frame deframer.
package tfd_pkg;

    // Frame layout: sync pair, version, sequence, count, records, CRC.
    localparam logic [7:0] SYNC0      = 8'hAA;
    localparam logic [7:0] SYNC1      = 8'h55;
    localparam logic [6:0] HDR_BYTES  = 7'd5;
    localparam int         REC_BYTES  = 8;

    // CRC-16/CCITT-FALSE: no reflection, no final xor.
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    // One byte handed to the bit-serial CRC unit.
    typedef struct packed {
        logic       start;
        logic       use_init;
        logic [7:0] data;
    } tfd_crc_cmd_t;

    // Request to emit the results of a frame that passed its CRC.
    typedef struct packed {
        logic       start;
        logic [7:0] seq;
        logic [3:0] count;
    } tfd_emit_req_t;

    // Emitter status seen by the parser.
    typedef struct packed {
        logic idle;
        logic busy;
    } tfd_emit_st_t;

endpackage

// File: hw/rtl/tfd_crc_unit.sv
// Bit-serial CRC-16/CCITT-FALSE unit: one polynomial step per clock.
module tfd_crc_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tfd_pkg::tfd_crc_cmd_t cmd,
    output logic [15:0]           crc,
    output logic                  busy
);
    import tfd_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;

    // Load folds the byte into the high half; each busy cycle shifts one bit.
    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            crc_next = (cmd.use_init ? CRC_INIT : crc_reg) ^ {cmd.data, 8'h00};
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ CRC_POLY)
                                   : {crc_reg[14:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            cnt_reg <= 4'd0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != 4'd0);

endmodule

// File: hw/rtl/tfd_emitter.sv
// Record buffer and result sequencer: one item per 8-byte record read, or one empty item.
module tfd_emitter #(
    parameter int MAX_TARGETS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        wr_en,
    input  logic [$clog2(MAX_TARGETS*tfd_pkg::REC_BYTES)-1:0] wr_addr,
    input  logic [7:0]                                  wr_data,
    input  tfd_pkg::tfd_emit_req_t                      req,
    output tfd_pkg::tfd_emit_st_t                       status,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [7:0]                                  frame_seq,
    output logic [3:0]                                  target_count,
    output logic [2:0]                                  target_index,
    output logic                                        target_present,
    output logic signed [15:0]                          range_cm,
    output logic signed [15:0]                          velocity_cms,
    output logic signed [15:0]                          angle_centideg,
    output logic [15:0]                                 snr_q8,
    output logic                                        last_of_frame
);
    import tfd_pkg::*;

    localparam int DEPTH = MAX_TARGETS * REC_BYTES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_FILL,
        E_OUT
    } emit_state_t;

    emit_state_t state_reg;
    emit_state_t state_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic [2:0]  k_reg;
    logic [2:0]  k_next;
    logic        pend_reg;
    logic [2:0]  pend_k_reg;
    logic        last_reg;
    logic        last_next;
    logic        present_reg;
    logic        present_next;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          clr_rec;
    logic [7:0]    rec_reg [REC_BYTES];
    logic [7:0]    seq_reg;
    logic [3:0]    count_reg;

    assign rd_en   = (state_reg == E_READ);
    assign rd_addr = AW'({idx_reg, k_reg});
    assign clr_rec = (state_reg == E_IDLE) && req.start && (req.count == 4'd0);

    // Sequencer next state.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        last_next    = last_reg;
        present_next = present_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    idx_next = 4'd0;
                    k_next   = 3'd0;
                    if (req.count == 4'd0)
                    begin
                        present_next = 1'b0;
                        last_next    = 1'b1;
                        state_next   = E_OUT;
                    end
                    else
                    begin
                        present_next = 1'b1;
                        state_next   = E_READ;
                    end
                end
            end
            E_READ:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    state_next = E_FILL;
                end
            end
            E_FILL:
            begin
                last_next  = (4'(idx_reg + 4'd1) == count_reg);
                state_next = E_OUT;
            end
            E_OUT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        k_next     = 3'd0;
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // State and registered control outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= E_IDLE;
            idx_reg     <= 4'd0;
            k_reg       <= 3'd0;
            pend_reg    <= 1'b0;
            pend_k_reg  <= 3'd0;
            last_reg    <= 1'b0;
            present_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            pend_reg    <= rd_en;
            pend_k_reg  <= k_reg;
            last_reg    <= last_next;
            present_reg <= present_next;
        end
    end

    // Record memory, registered read, and record assembly.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (clr_rec)
        begin
            for (int j = 0; j < REC_BYTES; j++)
            begin
                rec_reg[j] <= 8'h00;
            end
        end
        else if (pend_reg)
        begin
            rec_reg[pend_k_reg] <= rd_data_reg;
        end
        if ((state_reg == E_IDLE) && req.start)
        begin
            seq_reg   <= req.seq;
            count_reg <= req.count;
        end
    end

    assign status.idle = (state_reg == E_IDLE);
    assign status.busy = (state_reg != E_IDLE) && !((state_reg == E_OUT) && last_reg);

    // Result item, all from registers.
    assign out_valid      = (state_reg == E_OUT);
    assign frame_seq      = seq_reg;
    assign target_count   = count_reg;
    assign target_index   = idx_reg[2:0];
    assign target_present = present_reg;
    assign range_cm       = {rec_reg[1], rec_reg[0]};
    assign velocity_cms   = {rec_reg[3], rec_reg[2]};
    assign angle_centideg = {rec_reg[5], rec_reg[4]};
    assign snr_q8         = {rec_reg[7], rec_reg[6]};
    assign last_of_frame  = last_reg;

endmodule

// File: hw/rtl/target_frame_deframer_crc16_core.sv
// Top level of the sync-word framed target deframer with CRC-16/CCITT-FALSE.
// A byte that enters the CRC (sync, header and record bytes) is accepted and then stalls
// intake while the bit-serial CRC unit shifts it, which shifts one bit per clock.
// Bytes outside a frame, dropped bytes and the two CRC bytes do not start the CRC unit.
// At the end of a good frame each target is read byte by byte through the single read
// port of the record memory, then filled and output, plus any wait on out_ready; intake
// stalls until the final item of the frame is held in the output register. The record
// memory holds MAX_TARGETS*8 bytes and needs no clearing pass after reset.
module target_frame_deframer_crc16_core #(
    parameter int MAX_TARGETS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         frame_seq,
    output logic [3:0]         target_count,
    output logic [2:0]         target_index,
    output logic               target_present,
    output logic signed [15:0] range_cm,
    output logic signed [15:0] velocity_cms,
    output logic signed [15:0] angle_centideg,
    output logic [15:0]        snr_q8,
    output logic               last_of_frame
);
    import tfd_pkg::*;

    localparam int         AW     = $clog2(MAX_TARGETS * REC_BYTES);
    localparam logic [7:0] MT_CAP = 8'(MAX_TARGETS);

    localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] REG_MAX_TARGET_LIMIT = 2'd1;

    logic [7:0]    exp_ver_reg;
    logic [3:0]    max_lim_reg;
    logic [6:0]    bc_reg;
    logic [6:0]    bc_next;
    logic [7:0]    version_hold_reg;
    logic [7:0]    seq_hold_reg;
    logic [3:0]    count_hold_reg;
    logic [7:0]    crc_low_reg;
    logic [7:0]    version_hold_next;
    logic [7:0]    seq_hold_next;
    logic [3:0]    count_hold_next;
    logic [7:0]    crc_low_next;

    logic [6:0]    pay_end;
    logic          at_crc_hi;
    logic [7:0]    lim_eff;
    logic          in_fire;
    logic [15:0]   crc_val;
    logic          crc_busy;
    tfd_crc_cmd_t  crc_cmd;
    tfd_emit_req_t emit_req;
    tfd_emit_st_t  emit_st;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_ver_reg <= 8'd1;
            max_lim_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EXPECTED_VERSION: exp_ver_reg <= cfg_data;
                REG_MAX_TARGET_LIMIT: max_lim_reg <= cfg_data[3:0];
                default:              ;
            endcase
        end
    end

    // Last record byte sits just before the CRC; the high CRC byte follows the low one.
    assign pay_end   = HDR_BYTES + {count_hold_reg, 3'b000};
    assign at_crc_hi = (bc_reg >= HDR_BYTES) && (bc_reg == 7'(pay_end + 7'd1));
    assign lim_eff   = ({4'd0, max_lim_reg} > MT_CAP) ? MT_CAP : {4'd0, max_lim_reg};

    // Intake stalls while the CRC unit shifts, while results are read out, and at the
    // final CRC byte until the previous frame's last item has left.
    assign in_ready = !crc_busy && !emit_st.busy && !(at_crc_hi && !emit_st.idle);
    assign in_fire  = in_valid && in_ready;

    // Frame parser: byte position decides what each item means.
    always_comb
    begin
        bc_next           = bc_reg;
        version_hold_next = version_hold_reg;
        seq_hold_next     = seq_hold_reg;
        count_hold_next   = count_hold_reg;
        crc_low_next      = crc_low_reg;
        crc_cmd           = '0;
        crc_cmd.data      = rx_byte;
        emit_req          = '0;
        emit_req.seq      = seq_hold_reg;
        emit_req.count    = count_hold_reg;
        wr_en             = 1'b0;
        wr_addr           = AW'(bc_reg - HDR_BYTES);
        if (in_fire)
        begin
            if (bc_reg == 7'd0)
            begin
                if (rx_byte == SYNC0)
                begin
                    crc_cmd.start    = 1'b1;
                    crc_cmd.use_init = 1'b1;
                    bc_next          = 7'd1;
                end
            end
            else if (bc_reg == 7'd1)
            begin
                if (rx_byte == SYNC1)
                begin
                    crc_cmd.start = 1'b1;
                    bc_next       = 7'd2;
                end
                else
                begin
                    bc_next = 7'd0;
                end
            end
            else if (bc_reg == 7'd2)
            begin
                version_hold_next = rx_byte;
                crc_cmd.start     = 1'b1;
                bc_next           = 7'd3;
            end
            else if (bc_reg == 7'd3)
            begin
                seq_hold_next = rx_byte;
                crc_cmd.start = 1'b1;
                bc_next       = 7'd4;
            end
            else if (bc_reg == 7'd4)
            begin
                // Header check against the registers as they stand now.
                if ((version_hold_reg != exp_ver_reg) || (rx_byte > lim_eff))
                begin
                    bc_next = 7'd0;
                end
                else
                begin
                    count_hold_next = rx_byte[3:0];
                    crc_cmd.start   = 1'b1;
                    bc_next         = HDR_BYTES;
                end
            end
            else if (bc_reg < pay_end)
            begin
                wr_en         = 1'b1;
                crc_cmd.start = 1'b1;
                bc_next       = bc_reg + 7'd1;
            end
            else if (bc_reg == pay_end)
            begin
                crc_low_next = rx_byte;
                bc_next      = bc_reg + 7'd1;
            end
            else
            begin
                // High CRC byte: compare and hand a good frame to the emitter.
                bc_next        = 7'd0;
                emit_req.start = ({rx_byte, crc_low_reg} == crc_val);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg           <= 7'd0;
            version_hold_reg <= 8'd0;
            seq_hold_reg     <= 8'd0;
            count_hold_reg   <= 4'd0;
            crc_low_reg      <= 8'd0;
        end
        else
        begin
            bc_reg           <= bc_next;
            version_hold_reg <= version_hold_next;
            seq_hold_reg     <= seq_hold_next;
            count_hold_reg   <= count_hold_next;
            crc_low_reg      <= crc_low_next;
        end
    end

    tfd_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    tfd_emitter #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (rx_byte),
        .req            (emit_req),
        .status         (emit_st),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_seq      (frame_seq),
        .target_count   (target_count),
        .target_index   (target_index),
        .target_present (target_present),
        .range_cm       (range_cm),
        .velocity_cms   (velocity_cms),
        .angle_centideg (angle_centideg),
        .snr_q8         (snr_q8),
        .last_of_frame  (last_of_frame)
    );

    // No item is taken while the CRC unit is still shifting the previous byte.
    a_no_intake_during_crc: assert property (@(posedge clk) disable iff (!rst_n)
        crc_busy |-> !in_ready)
        else $error("item accepted while CRC unit busy");

    // A good frame is only handed over to an idle emitter.
    a_emit_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_req.start |-> emit_st.idle)
        else $error("emit request while emitter not idle");

    // An accepted target count never exceeds the record buffer.
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bc_reg >= HDR_BYTES) |-> (count_hold_reg <= MT_CAP[3:0] || MAX_TARGETS > 15))
        else $error("target count beyond buffer");

    // Byte position stays within the frame length derived from the count.
    a_position_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (bc_reg >= HDR_BYTES) |-> (bc_reg <= 7'(pay_end + 7'd1)))
        else $error("byte position past end of frame");

endmodule

// File: verif/tfd_tb_pkg.sv
// Register indexes and CRC helper shared by the deframer testbench files.
package tfd_tb_pkg;

    import tfd_pkg::*;

    // Configuration register indexes; the two spare indexes are ignored by the block.
    typedef enum logic [1:0] {
        REG_VERSION = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_SPARE2  = 2'd2,
        REG_SPARE3  = 2'd3
    } tfd_reg_e;

    // Register values after reset.
    localparam logic [7:0] VERSION_AT_RESET = 8'd1;
    localparam logic [3:0] LIMIT_AT_RESET   = 4'd8;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: verif/tfd_frame_checker.sv
// Checker that predicts the decoded target items of the deframer and compares them.
module tfd_frame_checker #(
    parameter int MAX_TARGETS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  frame_seq,
    input  logic [3:0]  target_count,
    input  logic [2:0]  target_index,
    input  logic        target_present,
    input  logic [15:0] range_cm,
    input  logic [15:0] velocity_cms,
    input  logic [15:0] angle_centideg,
    input  logic [15:0] snr_q8,
    input  logic        last_of_frame,
    output int          mismatch_total,
    output int          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import tfd_pkg::*;
    import tfd_tb_pkg::*;

    // Header byte positions within a frame, the CRC length and the report limit.
    localparam logic [6:0] POS_VERSION = 7'd2;
    localparam logic [6:0] POS_SEQ     = 7'd3;
    localparam logic [6:0] CRC_BYTES   = 7'd2;
    localparam int         REPORT_MAX  = 10;

    // One decoded target item as it appears on the output ports.
    typedef struct packed {
        logic [7:0]  seq;
        logic [3:0]  count;
        logic [2:0]  index;
        logic        present;
        logic [15:0] range_cm;
        logic [15:0] velocity_cms;
        logic [15:0] angle_centideg;
        logic [15:0] snr_q8;
        logic        last;
    } target_item_t;

    // Register copies.
    logic [7:0]   version_sel;
    logic [3:0]   limit_sel;

    // Deframer state.
    logic [6:0]   byte_cnt;
    logic [6:0]   frame_goal;
    logic [15:0]  crc_acc;
    logic [7:0]   seq_q;
    logic [7:0]   ver_q;
    logic [3:0]   count_q;
    logic [7:0]   crc_lo;
    logic [7:0]   rec_mem [MAX_TARGETS * REC_BYTES];

    target_item_t targets_due [$];
    int           fail_tally = 0;
    int           owed = 0;

    assign mismatch_total = fail_tally;
    assign results_owed   = owed;

    function automatic void restart_hunt();
        byte_cnt   = '0;
        frame_goal = '0;
    endfunction

    function automatic logic [15:0] record_word(input int off);
        return {rec_mem[off + 1], rec_mem[off]};
    endfunction

    // Queue the items of a frame whose CRC matched.
    function automatic void emit_frame();
        target_item_t t;
        int           i;
        t = '0;
        t.seq = seq_q;
        if (count_q == 0)
        begin
            t.last = 1'b1;
            targets_due.push_back(t);
        end
        else
        begin
            for (i = 0; i < count_q && i < MAX_TARGETS; i++)
            begin
                t.count          = count_q;
                t.index          = i[2:0];
                t.present        = 1'b1;
                t.range_cm       = record_word(i * REC_BYTES);
                t.velocity_cms   = record_word(i * REC_BYTES + 2);
                t.angle_centideg = record_word(i * REC_BYTES + 4);
                t.snr_q8         = record_word(i * REC_BYTES + 6);
                t.last           = (i + 1 == count_q);
                targets_due.push_back(t);
            end
        end
    endfunction

    // Advance the deframer by one received byte.
    function automatic void deframe_byte(input logic [7:0] b);
        int lim;
        lim = (limit_sel > MAX_TARGETS) ? MAX_TARGETS : limit_sel;
        if (byte_cnt == 0)
        begin
            // A wrong first byte is simply skipped.
            if (b == SYNC0)
            begin
                crc_acc  = crc16_step(CRC_INIT, b);
                byte_cnt = 7'd1;
            end
        end
        else if (byte_cnt == 1)
        begin
            // A wrong second byte drops the hunt and is not looked at again.
            if (b == SYNC1)
            begin
                crc_acc  = crc16_step(crc_acc, b);
                byte_cnt = 7'd2;
            end
            else
            begin
                restart_hunt();
            end
        end
        else if (byte_cnt < HDR_BYTES)
        begin
            if (byte_cnt == POS_VERSION)
            begin
                ver_q    = b;
                crc_acc  = crc16_step(crc_acc, b);
                byte_cnt = byte_cnt + 1;
            end
            else if (byte_cnt == POS_SEQ)
            begin
                seq_q    = b;
                crc_acc  = crc16_step(crc_acc, b);
                byte_cnt = byte_cnt + 1;
            end
            else if (ver_q != version_sel || int'(b) > lim)
            begin
                // Version and count are judged against the registers right now.
                restart_hunt();
            end
            else
            begin
                count_q    = b[3:0];
                frame_goal = 7'(int'(HDR_BYTES) + int'(b) * REC_BYTES + int'(CRC_BYTES));
                crc_acc    = crc16_step(crc_acc, b);
                byte_cnt   = byte_cnt + 1;
            end
        end
        else if (byte_cnt < frame_goal - CRC_BYTES)
        begin
            rec_mem[int'(byte_cnt - HDR_BYTES)] = b;
            crc_acc  = crc16_step(crc_acc, b);
            byte_cnt = byte_cnt + 1;
        end
        else if (byte_cnt == frame_goal - CRC_BYTES)
        begin
            crc_lo   = b;
            byte_cnt = byte_cnt + 1;
        end
        else
        begin
            // Final CRC byte: a mismatch drops the frame without a trace.
            restart_hunt();
            if ({b, crc_lo} == crc_acc)
                emit_frame();
        end
    endfunction

    function automatic string show_item(input target_item_t t);
        return $sformatf("seq=%h cnt=%0d idx=%0d pres=%b rng=%h vel=%h ang=%h snr=%h last=%b",
                         t.seq, t.count, t.index, t.present, t.range_cm, t.velocity_cms,
                         t.angle_centideg, t.snr_q8, t.last);
    endfunction

    // Compare one accepted output item with the oldest expected one.
    function automatic void check_item(input target_item_t got);
        target_item_t want;
        if (targets_due.size() == 0)
        begin
            fail_tally++;
            if (fail_tally <= REPORT_MAX)
                $display("%0t: unexpected item: %s", $realtime, show_item(got));
        end
        else
        begin
            want = targets_due.pop_front();
            if (got !== want)
            begin
                fail_tally++;
                if (fail_tally <= REPORT_MAX)
                    $display("%0t: item mismatch\n  expected %s\n  actual   %s",
                             $realtime, show_item(want), show_item(got));
            end
        end
    endfunction

    // Watch the configuration port and both channels.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_sel = VERSION_AT_RESET;
            limit_sel   = LIMIT_AT_RESET;
            restart_hunt();
            crc_acc     = CRC_INIT;
            seq_q       = '0;
            ver_q       = '0;
            count_q     = '0;
            crc_lo      = '0;
            targets_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (tfd_reg_e'(cfg_index))
                    REG_VERSION: version_sel = cfg_data;
                    REG_LIMIT:   limit_sel   = cfg_data[3:0];
                    default:     ;
                endcase
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            if (out_valid && out_ready)
                check_item({frame_seq, target_count, target_index, target_present, range_cm,
                            velocity_cms, angle_centideg, snr_q8, last_of_frame});
        end
        owed = targets_due.size();
    end

endmodule

// File: verif/target_frame_deframer_crc16_core_test.sv
// Top of the deframer testbench: clock, reset, byte stimulus and the final verdict.
module target_frame_deframer_crc16_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfd_pkg::*;
    import tfd_tb_pkg::*;

    localparam int TARGETS     = 8;
    localparam int BYTE_BUDGET = 420;
    localparam int PHASE_BYTES = 80;
    localparam int PHASES      = 5;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 16;
    localparam int TAIL        = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_VERSION;
    logic [7:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         frame_seq;
    logic [3:0]         target_count;
    logic [2:0]         target_index;
    logic               target_present;
    logic signed [15:0] range_cm;
    logic signed [15:0] velocity_cms;
    logic signed [15:0] angle_centideg;
    logic [15:0]        snr_q8;
    logic               last_of_frame;

    int                 mismatch_total;
    int                 results_owed;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;
    int                 stall_left = 0;
    bit                 sender_gaps = 1'b1;
    bit                 receiver_stalls = 1'b1;
    logic [7:0]         cur_version = VERSION_AT_RESET;
    logic [3:0]         cur_limit = LIMIT_AT_RESET;

    always #1 clk = ~clk;

    target_frame_deframer_crc16_core #(
        .MAX_TARGETS(TARGETS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_seq(frame_seq),
        .target_count(target_count),
        .target_index(target_index),
        .target_present(target_present),
        .range_cm(range_cm),
        .velocity_cms(velocity_cms),
        .angle_centideg(angle_centideg),
        .snr_q8(snr_q8),
        .last_of_frame(last_of_frame)
    );

    tfd_frame_checker #(
        .MAX_TARGETS(TARGETS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_seq(frame_seq),
        .target_count(target_count),
        .target_index(target_index),
        .target_present(target_present),
        .range_cm(range_cm),
        .velocity_cms(velocity_cms),
        .angle_centideg(angle_centideg),
        .snr_q8(snr_q8),
        .last_of_frame(last_of_frame),
        .mismatch_total(mismatch_total),
        .results_owed(results_owed)
    );

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Record words, with the 16-bit extremes mixed in.
    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 9) != 0)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Receiver side: random stalls on out_ready while enabled.
    always @(posedge clk)
    begin
        if (!receiver_stalls)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any item moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL target_frame_deframer_crc16_core");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one byte and wait until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop sending until every expected item has come out.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Write both registers, plus one of the ignored indexes, with the block idle.
    task automatic program_regs(input logic [7:0] ver, input logic [3:0] lim);
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VERSION;
        cfg_data  <= ver;
        @(posedge clk);
        cfg_index <= REG_LIMIT;
        cfg_data  <= {4'($urandom), lim};
        @(posedge clk);
        cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE2 : REG_SPARE3;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_version = ver;
        cur_limit   = lim;
    endtask

    // Build and send one frame; counts above the target capacity send the header only.
    task automatic send_frame(input logic [7:0] ver, input logic [7:0] cnt, input bit bad_crc);
        logic [7:0]  fb [$];
        logic [15:0] crc;
        logic [15:0] w;
        int          pos;
        int          n;
        fb.push_back(SYNC0);
        fb.push_back(SYNC1);
        fb.push_back(ver);
        fb.push_back(8'($urandom));
        fb.push_back(cnt);
        if (int'(cnt) <= TARGETS)
        begin
            for (n = 0; n < int'(cnt) * REC_BYTES / 2; n++)
            begin
                w = pick_word();
                fb.push_back(w[7:0]);
                fb.push_back(w[15:8]);
            end
            crc = CRC_INIT;
            foreach (fb[k])
                crc = crc16_step(crc, fb[k]);
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
            if (bad_crc)
            begin
                pos = $urandom_range(2, fb.size() - 1);
                fb[pos] = fb[pos] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
        foreach (fb[k])
            send_byte(fb[k]);
    endtask

    // Line noise, with plenty of first sync bytes to start false hunts.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 3)
                send_byte(SYNC0);
            else
                send_byte(8'($urandom));
        end
    endtask

    // Mostly good frames with random content; the rest broken frames and noise.
    task automatic send_random_frame();
        int         r;
        int         eff;
        logic [7:0] cnt;
        eff = (cur_limit > TARGETS) ? TARGETS : cur_limit;
        r   = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 5)
            cnt = 8'($urandom_range(0, (eff < 2) ? eff : 2));
        else if ($urandom_range(0, 9) < 8)
            cnt = 8'($urandom_range(0, eff));
        else
            cnt = 8'(eff);
        if (r < 65)
            send_frame(cur_version, cnt, 1'b0);
        else if (r < 77)
            send_frame(cur_version, cnt, 1'b1);
        else if (r < 84)
            send_frame(cur_version ^ 8'($urandom_range(1, 255)), cnt, 1'b0);
        else if (r < 90)
            send_frame(cur_version, 8'($urandom_range(eff + 1, 255)), 1'b0);
        else
            send_noise();
    endtask

    // Reset, directed cases, then random phases under several register settings.
    initial
    begin
        int phase;
        int phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Wrong first bytes at both extremes, then a wrong second byte.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC0);
        send_byte(SYNC0);
        send_byte(SYNC1);
        // Empty frame, wrong version, and a count above the limit.
        send_frame(cur_version, 8'd0, 1'b0);
        send_frame(cur_version + 8'd1, 8'd0, 1'b0);
        send_frame(cur_version, 8'(TARGETS + 1), 1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:       program_regs(8'h00, 4'hF);
                2:       program_regs(8'hFF, 4'h0);
                3:       program_regs(8'($urandom), 4'd3);
                4:       program_regs(VERSION_AT_RESET, LIMIT_AT_RESET);
                default: ;
            endcase
            // One phase runs with no idling on either side.
            sender_gaps     = (phase != 1);
            receiver_stalls = (phase != 1);
            phase_start     = items_sent;
            if (phase < PHASES - 1)
            begin
                while (items_sent - phase_start < PHASE_BYTES)
                    send_random_frame();
            end
            else
            begin
                while (items_sent < BYTE_BUDGET)
                    send_random_frame();
            end
        end

        hold_until_drained();
        repeat (TAIL) @(posedge clk);
        if (mismatch_total == 0 && results_owed == 0)
            $display("PASS target_frame_deframer_crc16_core");
        else
            $display("FAIL target_frame_deframer_crc16_core");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_crc_unit.sv
hw/rtl/tfd_emitter.sv
hw/rtl/target_frame_deframer_crc16_core.sv
verif/tfd_tb_pkg.sv
verif/tfd_frame_checker.sv
verif/target_frame_deframer_crc16_core_test.sv
